// ----- hdl/cbds_pkg.sv -----
// ----------------------------------------------------------------------------
// cbds_pkg
// Shared types and constants for the Collatz block-descent statistics engine.
// ----------------------------------------------------------------------------
package cbds_pkg;

    localparam int START_W     = 48;
    localparam int K_W         = 6;
    localparam int VAL_W       = 64;
    localparam int LIMIT_W     = 16;
    localparam int HALV_W      = 22;
    localparam int RUN_W       = 7;
    localparam int SEARCH_STEPS = $clog2(START_W);
    localparam int STEP_W      = $clog2(SEARCH_STEPS);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 16'd4096;
    localparam logic [VAL_W-1:0]   MAX_BEFORE_OVF = 64'h5555_5555_5555_5554;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_LIMIT    = 2'd3
    } cbds_status_t;

    // one classified start, front to back
    typedef struct packed {
        logic [START_W-1:0] start;
        logic [K_W-1:0]     k;
        logic               invalid;
    } cbds_job_t;

    // queue handshake between the parts
    typedef struct packed {
        logic push;
        logic pop;
    } cbds_qctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cbds_qsts_t;

endpackage

// ----- hdl/cbds_front.sv -----
// ----------------------------------------------------------------------------
// cbds_front
// Accepts start values, masks and validates them, and finds the block index
// with a binary search, one bit of the index per cycle.
// ----------------------------------------------------------------------------
module cbds_front #(
    parameter int START_BITS = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [cbds_pkg::START_W-1:0] start_value,
    input  cbds_pkg::cbds_qsts_t        q_sts,
    output logic                        q_push,
    output cbds_pkg::cbds_job_t         q_job
);
    import cbds_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE   = 3'b001,
        F_SEARCH = 3'b010,
        F_PUSH   = 3'b100
    } front_state_t;

    front_state_t       state_reg, state_next;
    logic [START_W-1:0] start_reg, start_next;
    logic [START_W-1:0] t_reg, t_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [STEP_W-1:0]  bit_reg, bit_next;
    logic               inval_reg, inval_next;

    logic [START_W-1:0] masked;
    logic [START_W-1:0] shifted;
    logic [K_W-1:0]     sh_amt;
    logic               accept;

    always_comb
    begin
        for (int i = 0; i < START_W; i++)
        begin
            masked[i] = start_value[i] & (i < START_BITS);
        end
    end

    assign in_stall = (state_reg != F_IDLE);
    assign accept   = in_valid && (state_reg == F_IDLE);
    assign sh_amt   = K_W'(1) << bit_reg;
    assign shifted  = t_reg >> sh_amt;

    always_comb
    begin
        state_next = state_reg;
        start_next = start_reg;
        t_next     = t_reg;
        k_next     = k_reg;
        bit_next   = bit_reg;
        inval_next = inval_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    start_next = masked;
                    t_next     = masked;
                    k_next     = '0;
                    bit_next   = STEP_W'(SEARCH_STEPS - 1);
                    inval_next = !masked[0] || (masked == START_W'(1));
                    state_next = (!masked[0] || (masked == START_W'(1))) ? F_PUSH : F_SEARCH;
                end
            end
            F_SEARCH:
            begin
                if (shifted != '0)
                begin
                    t_next = shifted;
                    k_next = k_reg | sh_amt;
                end
                if (bit_reg == '0)
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    bit_next = bit_reg - STEP_W'(1);
                end
            end
            F_PUSH:
            begin
                if (!q_sts.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        t_reg     <= t_next;
        k_reg     <= k_next;
        bit_reg   <= bit_next;
        inval_reg <= inval_next;
    end

    assign q_push        = (state_reg == F_PUSH) && !q_sts.full;
    assign q_job.start   = start_reg;
    assign q_job.k       = inval_reg ? '0 : k_reg;
    assign q_job.invalid = inval_reg;

    // a valid start lies in [2^k, 2^(k+1))
    a_k_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_job.invalid) |-> ((q_job.start >> q_job.k) == START_W'(1)))
        else $error("block index does not bracket the start");

endmodule

// ----- hdl/cbds_fifo.sv -----
// ----------------------------------------------------------------------------
// cbds_fifo
// Two-entry queue of classified starts between the front and the back.
// ----------------------------------------------------------------------------
module cbds_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cbds_pkg::cbds_qctl_t ctl,
    input  cbds_pkg::cbds_job_t  wr_job,
    output cbds_pkg::cbds_job_t  rd_job,
    output cbds_pkg::cbds_qsts_t sts
);
    import cbds_pkg::*;

    cbds_job_t   mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign sts.full  = (count_reg == 2'd2);
    assign sts.empty = (count_reg == 2'd0);
    assign do_push   = ctl.push && !sts.full;
    assign do_pop    = ctl.pop && !sts.empty;
    assign rd_job    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= 2'd2) && ((count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg)))
        else $error("queue count and pointers disagree");

endmodule

// ----- hdl/cbds_back.sv -----
// ----------------------------------------------------------------------------
// cbds_back
// Runs the reduced Collatz iteration for one start: 3n+1, trailing-zero
// count, strip, in the states B_CHECK, B_CTZ and B_SHIFT per odd step. Holds the result register.
// ----------------------------------------------------------------------------
module cbds_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cbds_pkg::LIMIT_W-1:0]  limit,
    input  cbds_pkg::cbds_job_t           q_job,
    input  cbds_pkg::cbds_qsts_t          q_sts,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [cbds_pkg::K_W-1:0]      block_index,
    output logic [cbds_pkg::VAL_W-1:0]    exit_value,
    output logic [cbds_pkg::LIMIT_W-1:0]  odd_step_count,
    output logic [cbds_pkg::HALV_W-1:0]   halving_step_count,
    output logic [cbds_pkg::RUN_W-1:0]    longest_halving_run,
    output logic [cbds_pkg::VAL_W-1:0]    peak_value
);
    import cbds_pkg::*;

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_CHECK = 5'b00010,
        B_CTZ   = 5'b00100,
        B_SHIFT = 5'b01000,
        B_EMIT  = 5'b10000
    } back_state_t;

    back_state_t        state_reg, state_next;
    cbds_status_t       st_reg, st_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [VAL_W-1:0]   lower_reg, lower_next;
    logic [VAL_W-1:0]   n_reg, n_next;
    logic [VAL_W-1:0]   m_reg, m_next;
    logic [VAL_W-1:0]   peak_reg, peak_next;
    logic [LIMIT_W-1:0] odd_reg, odd_next;
    logic [HALV_W-1:0]  halv_reg, halv_next;
    logic [RUN_W-1:0]   long_reg, long_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic               out_valid_reg, out_valid_next;

    logic [VAL_W-1:0]   low_bit;
    logic [RUN_W-1:0]   ctz;
    logic               slot_free;
    logic               emit;

    // isolate lowest set bit, then encode its position
    assign low_bit = m_reg & (~m_reg + VAL_W'(1));
    always_comb
    begin
        ctz = '0;
        for (int i = 0; i < VAL_W; i++)
        begin
            ctz = ctz | (low_bit[i] ? RUN_W'(i) : RUN_W'(0));
        end
    end

    assign slot_free = !out_valid_reg || !out_stall;
    assign emit      = (state_reg == B_EMIT) && slot_free;
    assign q_pop     = (state_reg == B_IDLE) && !q_sts.empty;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        k_next     = k_reg;
        lower_next = lower_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        peak_next  = peak_reg;
        odd_next   = odd_reg;
        halv_next  = halv_reg;
        long_next  = long_reg;
        run_next   = run_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_sts.empty)
                begin
                    odd_next  = '0;
                    halv_next = '0;
                    long_next = '0;
                    k_next    = q_job.k;
                    lower_next = VAL_W'(1) << q_job.k;
                    if (q_job.invalid)
                    begin
                        st_next    = ST_INVALID;
                        n_next     = '0;
                        peak_next  = '0;
                        state_next = B_EMIT;
                    end
                    else
                    begin
                        st_next    = ST_OK;
                        n_next     = VAL_W'(q_job.start);
                        peak_next  = VAL_W'(q_job.start);
                        state_next = B_CHECK;
                    end
                end
            end
            B_CHECK:
            begin
                priority if (n_reg < lower_reg)
                begin
                    st_next    = ST_OK;
                    state_next = B_EMIT;
                end
                else if (odd_reg >= limit)
                begin
                    st_next    = ST_LIMIT;
                    state_next = B_EMIT;
                end
                else if (n_reg > MAX_BEFORE_OVF)
                begin
                    st_next    = ST_OVERFLOW;
                    state_next = B_EMIT;
                end
                else
                begin
                    m_next     = n_reg + {n_reg[VAL_W-2:0], 1'b0} + VAL_W'(1);
                    odd_next   = odd_reg + LIMIT_W'(1);
                    state_next = B_CTZ;
                end
            end
            B_CTZ:
            begin
                run_next = ctz;
                if (m_reg > peak_reg)
                begin
                    peak_next = m_reg;
                end
                state_next = B_SHIFT;
            end
            B_SHIFT:
            begin
                n_next    = m_reg >> run_reg;
                halv_next = halv_reg + HALV_W'(run_reg);
                if (run_reg > long_reg)
                begin
                    long_next = run_reg;
                end
                state_next = B_CHECK;
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg    <= st_next;
        k_reg     <= k_next;
        lower_reg <= lower_next;
        n_reg     <= n_next;
        m_reg     <= m_next;
        peak_reg  <= peak_next;
        odd_reg   <= odd_next;
        halv_reg  <= halv_next;
        long_reg  <= long_next;
        run_reg   <= run_next;
        if (emit)
        begin
            status              <= st_reg;
            block_index         <= k_reg;
            exit_value          <= n_reg;
            odd_step_count      <= odd_reg;
            halving_step_count  <= halv_reg;
            longest_halving_run <= long_reg;
            peak_value          <= peak_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // the working value is odd between steps; 3n+1 of an odd value is even
    a_n_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CHECK) |-> n_reg[0])
        else $error("working value even at step check");

    a_m_even: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CTZ) |-> (!m_reg[0] && (m_reg != '0)))
        else $error("3n+1 value odd or zero");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CTZ) |-> (odd_reg <= limit))
        else $error("odd steps passed the limit");

endmodule

// ----- hdl/collatz_block_descent_stats.sv -----
// Path of a valid start from transaction accept to result accept: accept, index search,
// queue, load, the B_CHECK/B_CTZ/B_SHIFT states per odd step, final check, emit.
// The front raises in_stall until its current start is pushed into the queue, so it can take
// a new start while the back-end step loop (3n+1, trailing-zero count, strip) runs the last one.
// Reset: rst_n is asynchronous; it empties the queue, idles both parts and sets
// the odd-step limit register limit_reg to 4096.
// ----------------------------------------------------------------------------
// collatz_block_descent_stats
// Top level: config register, classifying front, two-entry queue, step engine.
// ----------------------------------------------------------------------------
module collatz_block_descent_stats #(
    parameter int START_BITS = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cbds_pkg::LIMIT_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cbds_pkg::START_W-1:0]  start_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [cbds_pkg::K_W-1:0]      block_index,
    output logic [cbds_pkg::VAL_W-1:0]    exit_value,
    output logic [cbds_pkg::LIMIT_W-1:0]  odd_step_count,
    output logic [cbds_pkg::HALV_W-1:0]   halving_step_count,
    output logic [cbds_pkg::RUN_W-1:0]    longest_halving_run,
    output logic [cbds_pkg::VAL_W-1:0]    peak_value
);
    import cbds_pkg::*;

    logic [LIMIT_W-1:0] limit_reg, limit_next;
    cbds_qctl_t         q_ctl;
    cbds_qsts_t         q_sts;
    cbds_job_t          wr_job;
    cbds_job_t          rd_job;
    logic               q_push;
    logic               q_pop;

    assign cfg_ready  = 1'b1;
    assign limit_next = (cfg_valid && cfg_ready) ? cfg_data : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign q_ctl.push = q_push;
    assign q_ctl.pop  = q_pop;

    cbds_front #(
        .START_BITS (START_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_value (start_value),
        .q_sts       (q_sts),
        .q_push      (q_push),
        .q_job       (wr_job)
    );

    cbds_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (q_ctl),
        .wr_job (wr_job),
        .rd_job (rd_job),
        .sts    (q_sts)
    );

    cbds_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .limit               (limit_reg),
        .q_job               (rd_job),
        .q_sts               (q_sts),
        .q_pop               (q_pop),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .status              (status),
        .block_index         (block_index),
        .exit_value          (exit_value),
        .odd_step_count      (odd_step_count),
        .halving_step_count  (halving_step_count),
        .longest_halving_run (longest_halving_run),
        .peak_value          (peak_value)
    );

endmodule
